// File: hdl/clmp_pkg.sv
package clmp_pkg;

  localparam int MASK_BITS_DEF   = 64;
  localparam int NUMBER_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_COMMA,
    TK_DASH,
    TK_SPACE,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic       last;
  } token_t;

endpackage

// File: hdl/clmp_ifs.sv
interface clmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface clmp_out_if #(
  parameter int MASK_BITS = clmp_pkg::MASK_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [MASK_BITS-1:0] cpu_mask;
  logic                 format_error;

  modport source (output valid, output cpu_mask, output format_error, input ready);
  modport sink (input valid, input cpu_mask, input format_error, output ready);
endinterface

// File: hdl/clmp_front.sv
module clmp_front (
  input  logic [7:0]     char_code,
  input  logic           end_of_text,
  output clmp_pkg::token_t tok
);

  logic [7:0] offset;

  assign offset = char_code - clmp_pkg::CH_ZERO;

  always_comb begin
    tok.last  = end_of_text;
    tok.digit = offset[3:0];
    if (char_code >= clmp_pkg::CH_ZERO && char_code <= clmp_pkg::CH_NINE) begin
      tok.kind = clmp_pkg::TK_DIGIT;
    end else if (char_code == clmp_pkg::CH_COMMA) begin
      tok.kind = clmp_pkg::TK_COMMA;
    end else if (char_code == clmp_pkg::CH_DASH) begin
      tok.kind = clmp_pkg::TK_DASH;
    end else if (char_code == clmp_pkg::CH_SPACE ||
                 (char_code >= clmp_pkg::CH_TAB && char_code <= clmp_pkg::CH_CR)) begin
      tok.kind = clmp_pkg::TK_SPACE;
    end else begin
      tok.kind = clmp_pkg::TK_OTHER;
    end
  end

endmodule

// File: hdl/clmp_queue.sv
module clmp_queue #(
  parameter int DEPTH = clmp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  clmp_pkg::token_t push_tok,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output clmp_pkg::token_t pop_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  clmp_pkg::token_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_tok   = mem[rd_ptr];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/clmp_back.sv
module clmp_back #(
  parameter int MASK_BITS   = clmp_pkg::MASK_BITS_DEF,
  parameter int NUMBER_BITS = clmp_pkg::NUMBER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  input  clmp_pkg::token_t tok,
  output logic             tok_pop,
  clmp_out_if.source       results
);

  localparam int IDX = $clog2(MASK_BITS);
  localparam int AW  = NUMBER_BITS + 4;
  localparam logic [IDX-1:0] TOP_IDX = IDX'(MASK_BITS - 1);
  localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;

  logic [NUMBER_BITS-1:0] number_acc,  number_acc_next;
  logic                   number_seen, number_seen_next;
  logic [NUMBER_BITS-1:0] range_start, range_start_next;
  logic                   range_open,  range_open_next;
  logic [MASK_BITS-1:0]   mask_acc,    mask_acc_next;
  logic                   error_seen,  error_seen_next;

  logic                   out_valid;
  logic [MASK_BITS-1:0]   out_mask;
  logic                   out_error;

  logic [NUMBER_BITS-1:0] acc1;
  logic                   seen1;
  logic [NUMBER_BITS-1:0] rs1;
  logic                   ro1;
  logic                   err1;
  logic                   err2;
  logic                   is_comma;
  logic                   do_close;
  logic [AW-1:0]          acc_x10;
  logic [NUMBER_BITS-1:0] lo;
  logic [MASK_BITS-1:0]   span;
  logic [MASK_BITS-1:0]   mask1;

  assign tok_pop = tok_valid && (!tok.last || !out_valid || results.ready);

  assign acc_x10 = {1'b0, number_acc, 3'b000} + {3'b000, number_acc, 1'b0} + AW'(tok.digit);

  always_comb begin
    acc1     = number_acc;
    seen1    = number_seen;
    rs1      = range_start;
    ro1      = range_open;
    err1     = error_seen;
    is_comma = 1'b0;
    if (!error_seen) begin
      case (tok.kind)
        clmp_pkg::TK_DIGIT: begin
          acc1  = (acc_x10 > AW'(NUM_MAX)) ? NUM_MAX : acc_x10[NUMBER_BITS-1:0];
          seen1 = 1'b1;
        end
        clmp_pkg::TK_COMMA: begin
          is_comma = 1'b1;
        end
        clmp_pkg::TK_SPACE: begin
        end
        clmp_pkg::TK_DASH: begin
          if (!number_seen || range_open) begin
            err1 = 1'b1;
          end else begin
            rs1   = number_acc;
            ro1   = 1'b1;
            seen1 = 1'b0;
            acc1  = '0;
          end
        end
        default: begin
          err1 = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    logic [IDX-1:0] hi_idx;
    logic [IDX-1:0] lo_idx;
    hi_idx = (acc1 >= NUMBER_BITS'(MASK_BITS)) ? TOP_IDX : acc1[IDX-1:0];
    lo     = ro1 ? rs1 : acc1;
    lo_idx = lo[IDX-1:0];
    if (lo > acc1 || lo >= NUMBER_BITS'(MASK_BITS)) begin
      span = '0;
    end else begin
      span = ({MASK_BITS{1'b1}} << lo_idx) & ({MASK_BITS{1'b1}} >> (TOP_IDX - hi_idx));
    end
  end

  assign do_close = !err1 && (is_comma || tok.last);
  assign mask1    = (do_close && seen1) ? (mask_acc | span) : mask_acc;
  assign err2     = err1 || (do_close && (!seen1 || (is_comma && tok.last)));

  always_comb begin
    number_acc_next  = acc1;
    number_seen_next = seen1;
    range_start_next = rs1;
    range_open_next  = ro1;
    mask_acc_next    = mask1;
    error_seen_next  = err2;
    if (do_close && seen1) begin
      number_acc_next  = '0;
      number_seen_next = 1'b0;
      range_open_next  = 1'b0;
    end
    if (tok.last) begin
      number_acc_next  = '0;
      number_seen_next = 1'b0;
      range_start_next = '0;
      range_open_next  = 1'b0;
      mask_acc_next    = '0;
      error_seen_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_acc  <= '0;
      number_seen <= 1'b0;
      range_start <= '0;
      range_open  <= 1'b0;
      mask_acc    <= '0;
      error_seen  <= 1'b0;
    end else if (tok_pop) begin
      number_acc  <= number_acc_next;
      number_seen <= number_seen_next;
      range_start <= range_start_next;
      range_open  <= range_open_next;
      mask_acc    <= mask_acc_next;
      error_seen  <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_pop && tok.last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && tok.last) begin
      out_mask  <= err2 ? '0 : mask1;
      out_error <= err2;
    end
  end

  assign results.valid        = out_valid;
  assign results.cpu_mask     = out_mask;
  assign results.format_error = out_error;

endmodule

// File: hdl/cpu_list_to_mask_parser_core.sv
// Channel   Dir  Transaction
// chars     in   one text byte: char_code, end_of_text
// results   out  one per text: cpu_mask, format_error
//
// Throughput: one byte per cycle while the token queue has room; the back end
// retires one token a cycle, a final one only while the result slot is free.
// Reset: rst clears the token queue, the parser state and the result valid.
// Stalls: a held result blocks only the final byte of the next text; other
// bytes keep flowing until the token queue fills. The result is registered.
module cpu_list_to_mask_parser_core #(
  parameter int MASK_BITS   = clmp_pkg::MASK_BITS_DEF,
  parameter int NUMBER_BITS = clmp_pkg::NUMBER_BITS_DEF,
  parameter int QUEUE_DEPTH = clmp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  clmp_in_if.sink    chars,
  clmp_out_if.source results
);

  clmp_pkg::token_t front_tok;
  clmp_pkg::token_t queue_tok;
  logic             queue_full;
  logic             queue_valid;
  logic             back_pop;

  assign chars.ready = !queue_full;

  clmp_front u_front (
    .char_code   (chars.char_code),
    .end_of_text (chars.end_of_text),
    .tok         (front_tok)
  );

  clmp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (chars.valid),
    .push_tok  (front_tok),
    .full      (queue_full),
    .pop       (back_pop),
    .not_empty (queue_valid),
    .pop_tok   (queue_tok)
  );

  clmp_back #(
    .MASK_BITS   (MASK_BITS),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (queue_valid),
    .tok       (queue_tok),
    .tok_pop   (back_pop),
    .results   (results)
  );

endmodule

// File: sim/testbench.sv
module testbench;

  localparam int MASK_W      = clmp_pkg::MASK_BITS_DEF;
  localparam int NUM_MAX     = (1 << clmp_pkg::NUMBER_BITS_DEF) - 1;
  localparam int ITEM_TARGET = 1500;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 10;

  typedef struct packed {
    logic [MASK_W-1:0] cpu_mask;
    logic              format_error;
  } mask_result_t;

  typedef struct {
    bit           typed;
    mask_result_t res;
  } text_override_t;

  typedef struct {
    string             text;
    bit                typed;
    logic [MASK_W-1:0] cpu_mask;
    bit                format_error;
  } text_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clmp_in_if chars_if ();
  clmp_out_if #(.MASK_BITS(MASK_W)) results_if ();

  cpu_list_to_mask_parser_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  always #4 clk = ~clk;

  // parser mirror
  int unsigned       acc_num;
  bit                have_digits;
  int unsigned       lo_bound;
  bit                in_range;
  logic [MASK_W-1:0] cpus_so_far;
  bit                malformed;

  mask_result_t   mask_expect_q[$];
  text_override_t override_q[$];
  logic [7:0]     text_q[$];
  int             mismatches = 0;
  int             bytes_sent = 0;
  bit             calm = 1'b0;
  int             stall_cycles = 0;

  function automatic logic [MASK_W-1:0] span_bits(int unsigned lo, int unsigned hi);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i >= lo && i <= hi) m[i] = 1'b1;
    end
    return m;
  endfunction

  function void clear_parser();
    acc_num     = 0;
    have_digits = 1'b0;
    lo_bound    = 0;
    in_range    = 1'b0;
    cpus_so_far = '0;
    malformed   = 1'b0;
  endfunction

  function void close_entry();
    if (!have_digits) begin
      malformed = 1'b1;
    end else begin
      cpus_so_far |= span_bits(in_range ? lo_bound : acc_num, acc_num);
      in_range    = 1'b0;
      have_digits = 1'b0;
      acc_num     = 0;
    end
  endfunction

  function void parse_byte(input logic [7:0] c, input bit last, output bit done,
                           output mask_result_t res);
    int unsigned grown;
    done = 1'b0;
    res  = '0;
    if (!malformed) begin
      if (c == clmp_pkg::CH_COMMA) begin
        close_entry();
      end else if (c >= clmp_pkg::CH_ZERO && c <= clmp_pkg::CH_NINE) begin
        grown       = acc_num * 10 + int'(c - clmp_pkg::CH_ZERO);
        acc_num     = (grown > NUM_MAX) ? NUM_MAX : grown;
        have_digits = 1'b1;
      end else if (c == clmp_pkg::CH_SPACE ||
                   (c >= clmp_pkg::CH_TAB && c <= clmp_pkg::CH_CR)) begin
      end else if (c == clmp_pkg::CH_DASH) begin
        if (!have_digits || in_range) begin
          malformed = 1'b1;
        end else begin
          lo_bound    = acc_num;
          in_range    = 1'b1;
          have_digits = 1'b0;
          acc_num     = 0;
        end
      end else begin
        malformed = 1'b1;
      end
    end
    if (last) begin
      if (!malformed) close_entry();
      res.cpu_mask     = malformed ? '0 : cpus_so_far;
      res.format_error = malformed;
      done             = 1'b1;
      clear_parser();
    end
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    mask_result_t   want;
    mask_result_t   got;
    text_override_t ov;
    bit             done;
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        got.cpu_mask     = results_if.cpu_mask;
        got.format_error = results_if.format_error;
        if (mask_expect_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result mask=%h err=%b",
                                  got.cpu_mask, got.format_error));
        end else begin
          want = mask_expect_q.pop_front();
          if (got.cpu_mask !== want.cpu_mask)
            flag_mismatch($sformatf("cpu_mask %h, want %h", got.cpu_mask, want.cpu_mask));
          if (got.format_error !== want.format_error)
            flag_mismatch($sformatf("format_error %b, want %b",
                                    got.format_error, want.format_error));
        end
      end
      if (chars_if.valid && chars_if.ready) begin
        parse_byte(chars_if.char_code, chars_if.end_of_text, done, want);
        if (done) begin
          ov = override_q.pop_front();
          if (ov.typed) want = ov.res;
          mask_expect_q.push_back(want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) ||
        (results_if.valid && results_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(negedge clk) begin
    results_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 23);
  end

  task automatic send_byte(input logic [7:0] c, input bit last);
    while (!calm && $urandom_range(0, 99) < 23) begin
      chars_if.valid <= 1'b0;
      @(negedge clk);
    end
    chars_if.valid       <= 1'b1;
    chars_if.char_code   <= c;
    chars_if.end_of_text <= last;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    bytes_sent++;
    calm = (bytes_sent >= 600 && bytes_sent < 900);
    @(negedge clk);
  endtask

  task automatic send_text(input bit typed, input mask_result_t typed_res);
    text_override_t ov;
    ov.typed = typed;
    ov.res   = typed_res;
    override_q.push_back(ov);
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? clmp_pkg::CH_SPACE : clmp_pkg::CH_TAB + k[7:0];
  endfunction

  function void add_char(input logic [7:0] c);
    if ($urandom_range(0, 9) == 0) text_q.push_back(pick_space());
    text_q.push_back(c);
  endfunction

  function void add_number();
    int    n;
    int    k;
    string s;
    k = $urandom_range(0, 99);
    if (k < 80)      n = $urandom_range(0, 70);
    else if (k < 95) n = $urandom_range(0, 999);
    else             n = $urandom_range(0, 99999);
    s = $sformatf("%0d", n);
    if ($urandom_range(0, 9) == 0) add_char(clmp_pkg::CH_ZERO);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function void build_good();
    int items;
    items = $urandom_range(1, 4);
    for (int i = 0; i < items; i++) begin
      if (i > 0) add_char(clmp_pkg::CH_COMMA);
      add_number();
      if ($urandom_range(0, 9) < 4) begin
        add_char(clmp_pkg::CH_DASH);
        add_number();
      end
    end
    if ($urandom_range(0, 9) == 0) text_q.push_back(pick_space());
  endfunction

  function void build_broken();
    case ($urandom_range(0, 5))
      0: begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          text_q.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        build_good();
        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
      2: begin
        build_good();
        add_char(clmp_pkg::CH_COMMA);
      end
      3: begin
        add_number();
        add_char(clmp_pkg::CH_DASH);
        if ($urandom_range(0, 1)) add_number();
        add_char(clmp_pkg::CH_DASH);
        add_number();
      end
      4: begin
        for (int i = $urandom_range(1, 3); i > 0; i--) text_q.push_back(pick_space());
      end
      default: begin
        add_char($urandom_range(0, 1) ? clmp_pkg::CH_COMMA : clmp_pkg::CH_DASH);
        build_good();
      end
    endcase
  endfunction

  text_row_t dir_rows[12];

  initial begin
    dir_rows = '{
      '{"0",      1'b1, 64'h1,                  1'b0},
      '{"63",     1'b1, 64'h8000_0000_0000_0000, 1'b0},
      '{"0-63",   1'b1, '1,                     1'b0},
      '{"5-2",    1'b1, 64'h0,                  1'b0},
      '{",",      1'b1, 64'h0,                  1'b1},
      '{"1-2-",   1'b1, 64'h0,                  1'b1},
      '{"\377",   1'b1, 64'h0,                  1'b1},
      '{"3,",     1'b1, 64'h0,                  1'b1},
      '{" ",      1'b1, 64'h0,                  1'b1},
      '{" 1\t2",  1'b0, 64'h0,                  1'b0},
      '{"99999",  1'b0, 64'h0,                  1'b0},
      '{"60-70",  1'b0, 64'h0,                  1'b0}
    };
    clear_parser();
    chars_if.valid       = 1'b0;
    chars_if.char_code   = '0;
    chars_if.end_of_text = 1'b0;
    results_if.ready     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      text_q.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) text_q.push_back(dir_rows[r].text[i]);
      send_text(dir_rows[r].typed, '{dir_rows[r].cpu_mask, dir_rows[r].format_error});
    end

    while (bytes_sent < ITEM_TARGET) begin
      text_q.delete();
      if ($urandom_range(0, 99) < 80) build_good();
      else build_broken();
      send_text(1'b0, '0);
    end
    chars_if.valid <= 1'b0;

    while (mask_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && mask_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/clmp_pkg.sv
hdl/clmp_ifs.sv
hdl/clmp_front.sv
hdl/clmp_queue.sv
hdl/clmp_back.sv
hdl/cpu_list_to_mask_parser_core.sv
sim/testbench.sv
